// ===== sv/spn64_pkg.sv =====
// Shared constants, register codes and round helper functions for the SPN64 cipher.
`default_nettype none

package spn64_pkg;

	localparam int unsigned ROUNDS_DEF = 8;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned KEY_W      = 128;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_index_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Eight parallel S-box lookups.
	function automatic word_t sub_bytes(input word_t v);
		word_t r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = SBOX[v[8*i +: 8]];
		end
		return r;
	endfunction

	// 8x8 bit-matrix transpose, bits numbered from the MSB: bit 8a+b -> bit 8b+a.
	function automatic word_t transpose(input word_t v);
		word_t r;
		r = '0;
		for (int a = 0; a < 8; a++) begin
			for (int b = 0; b < 8; b++) begin
				r[63 - (8*b + a)] = v[63 - (8*a + b)];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/spn64_block_encrypt.sv =====
// SPN64 block encrypt: 64-bit substitution-permutation cipher, one round per pipeline stage.
//
// Input channel: in_valid / in_stall / plaintext. A word is taken at a clock edge with
// in_valid high and in_stall low. Output channel: out_valid / out_stall / ciphertext,
// same rule. Config port: cfg_write / cfg_index / cfg_data writes key_high (index 0) or
// key_low (index 1); write only while no words are in flight.
//
// Each round has its own stage register; the last stage also applies the closing key XOR
// and is the output register. Throughput is one word per cycle while out_stall is low;
// every stage's ready looks only at its own valid and the next stage's ready, so bubbles
// are squeezed out while the output is stalled.
// When out_stall is high the last stage holds its word; earlier stages keep filling and
// in_stall rises only once every stage holds a word.
// Reset (arst_n low) empties the pipeline and clears both key registers to zero.
`default_nettype none

module spn64_block_encrypt #(
	parameter int unsigned ROUNDS = spn64_pkg::ROUNDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  spn64_pkg::word_t      plaintext,
	output logic                  out_valid,
	input  logic                  out_stall,
	output spn64_pkg::word_t      ciphertext,
	input  logic                  cfg_write,
	input  spn64_pkg::reg_index_t cfg_index,
	input  spn64_pkg::word_t      cfg_data
);
	import spn64_pkg::*;

	word_t             key_high_q;
	word_t             key_low_q;
	logic [KEY_W-1:0]  key_all;
	word_t             final_key;

	word_t             word_s  [ROUNDS];
	logic [ROUNDS-1:0] valid_s;
	logic [ROUNDS:0]   rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key_all   = {key_high_q, key_low_q};
	// round key r is the 8-byte window starting at key byte r-1
	assign final_key = key_all[KEY_W-1-8*ROUNDS -: WORD_W];

	assign rdy[ROUNDS] = !out_stall;

	genvar k;
	generate
		for (k = 0; k < ROUNDS; k++) begin : g_stage
			word_t stage_in;
			word_t stage_out;
			word_t stage_next;
			logic  stage_in_valid;

			if (k == 0) begin : g_first
				assign stage_in       = plaintext;
				assign stage_in_valid = in_valid;
			end else begin : g_inner
				assign stage_in       = word_s[k-1];
				assign stage_in_valid = valid_s[k-1];
			end

			spn64_round #(
				.LAST (k == ROUNDS - 1)
			) u_round (
				.round_key (key_all[KEY_W-1-8*k -: WORD_W]),
				.din       (stage_in),
				.dout      (stage_out)
			);

			if (k == ROUNDS - 1) begin : g_whiten
				assign stage_next = stage_out ^ final_key;
			end else begin : g_pass
				assign stage_next = stage_out;
			end

			assign rdy[k] = !valid_s[k] || rdy[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					valid_s[k] <= stage_in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && stage_in_valid) begin
					word_s[k] <= stage_next;
				end
			end
		end
	endgenerate

	assign in_stall   = !rdy[0];
	assign out_valid  = valid_s[ROUNDS-1];
	assign ciphertext = word_s[ROUNDS-1];

	// input backs up only when every stage is full and the output is blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&valid_s) && out_stall)
		else $error("input stalled with a free pipeline slot");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage empty");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && cfg_index == REG_KEY_LOW |=> key_low_q == $past(cfg_data))
		else $error("key_low write lost");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s[0] && !in_valid |=> !valid_s[0])
		else $error("word appeared in first stage without input");

endmodule

`default_nettype wire

// ===== sv/spn64_round.sv =====
// One SPN64 round: round key XOR, byte substitution, optional bit transpose.
`default_nettype none

module spn64_round #(
	parameter bit LAST = 1'b0
) (
	input  spn64_pkg::word_t round_key,
	input  spn64_pkg::word_t din,
	output spn64_pkg::word_t dout
);
	import spn64_pkg::*;

	word_t subbed;

	assign subbed = sub_bytes(din ^ round_key);

	// final round skips the permutation
	generate
		if (LAST) begin : g_last
			assign dout = subbed;
		end else begin : g_mid
			assign dout = transpose(subbed);
		end
	endgenerate

endmodule

`default_nettype wire
